FILE: hdl/egcd_pkg.sv
// Shared types, constants and the microcode program for the extended GCD block.
// Used by egcd_seq, egcd_dpath, the top level and the checker. No dependencies.
package egcd_pkg;

  localparam int OPND_W = 31;  // operand, gcd and inverse field width
  localparam int COEF_W = 32;  // Bezout coefficient field width
  localparam int PC_W   = 4;

  typedef struct packed {
    logic [OPND_W-1:0] a_value;
    logic [OPND_W-1:0] b_value;
  } in_word_t;

  typedef struct packed {
    logic [OPND_W-1:0]        gcd_value;
    logic signed [COEF_W-1:0] bezout_x;
    logic signed [COEF_W-1:0] bezout_y;
    logic [OPND_W-1:0]        inverse_value;
    logic                     inverse_exists;
  } out_word_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_INIT,
    OP_ALIGN,
    OP_SUB,
    OP_SWAP,
    OP_FINISH,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NONE,
    C_ALWAYS,
    C_NO_START,
    C_R1_ZERO,
    C_ALIGN,
    C_CNT_NZ
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } uword_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    logic r1_zero;
    logic align_ok;
    logic cnt_nz;
  } status_t;

  // step addresses
  localparam logic [PC_W-1:0] UA_IDLE   = 4'd0;
  localparam logic [PC_W-1:0] UA_LOAD   = 4'd1;
  localparam logic [PC_W-1:0] UA_TEST   = 4'd2;
  localparam logic [PC_W-1:0] UA_INIT   = 4'd3;
  localparam logic [PC_W-1:0] UA_ALIGN  = 4'd4;
  localparam logic [PC_W-1:0] UA_SUB    = 4'd5;
  localparam logic [PC_W-1:0] UA_SWAP   = 4'd6;
  localparam logic [PC_W-1:0] UA_FINISH = 4'd7;
  localparam logic [PC_W-1:0] UA_EMIT   = 4'd8;

  // Program: jump to target when cond holds, else fall through to pc+1.
  // Operands are loaded on every idle cycle, so the last load is the accepted word.
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      UA_IDLE:   w = '{op: OP_LOAD,   cond: C_NO_START, target: UA_IDLE};
      UA_LOAD:   w = '{op: OP_NOP,    cond: C_NONE,     target: UA_IDLE};
      UA_TEST:   w = '{op: OP_NOP,    cond: C_R1_ZERO,  target: UA_FINISH};
      UA_INIT:   w = '{op: OP_INIT,   cond: C_NONE,     target: UA_IDLE};
      UA_ALIGN:  w = '{op: OP_ALIGN,  cond: C_ALIGN,    target: UA_ALIGN};
      UA_SUB:    w = '{op: OP_SUB,    cond: C_CNT_NZ,   target: UA_SUB};
      UA_SWAP:   w = '{op: OP_SWAP,   cond: C_ALWAYS,   target: UA_TEST};
      UA_FINISH: w = '{op: OP_FINISH, cond: C_NONE,     target: UA_IDLE};
      UA_EMIT:   w = '{op: OP_EMIT,   cond: C_ALWAYS,   target: UA_IDLE};
      default:   w = '{op: OP_NOP,    cond: C_ALWAYS,   target: UA_IDLE};
    endcase
    return w;
  endfunction

endpackage

FILE: hdl/egcd_seq.sv
// Microcode sequencer: step counter, program table lookup and conditional jumps.
// Depends on egcd_pkg.
module egcd_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  egcd_pkg::status_t  status,
  output egcd_pkg::op_t      op,
  output logic               busy
);

  logic [egcd_pkg::PC_W-1:0] pc;
  logic [egcd_pkg::PC_W-1:0] pc_next;
  egcd_pkg::uword_t          uw;
  logic                      take;

  assign uw = egcd_pkg::ucode(pc);

  always_comb begin
    unique case (uw.cond)
      egcd_pkg::C_NONE:     take = 1'b0;
      egcd_pkg::C_ALWAYS:   take = 1'b1;
      egcd_pkg::C_NO_START: take = !start;
      egcd_pkg::C_R1_ZERO:  take = status.r1_zero;
      egcd_pkg::C_ALIGN:    take = status.align_ok;
      egcd_pkg::C_CNT_NZ:   take = status.cnt_nz;
      default:              take = 1'b1;
    endcase
    pc_next = take ? uw.target : pc + egcd_pkg::PC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= egcd_pkg::UA_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  assign op   = uw.op;
  assign busy = (pc != egcd_pkg::UA_IDLE);

endmodule

FILE: hdl/egcd_dpath.sv
// Datapath: remainder and coefficient registers, shift-subtract quotient steps,
// inverse normalization and result register. Depends on egcd_pkg.
module egcd_dpath #(
  parameter int DW = 31
) (
  input  logic                 clk,
  input  logic                 rst,
  input  egcd_pkg::op_t        op,
  input  egcd_pkg::in_word_t   operands,
  output egcd_pkg::status_t    status,
  output logic                 done,
  output egcd_pkg::out_word_t  result
);

  localparam int SW = DW + 2;                                      // coefficient width
  localparam int CW = (DW > 1) ? $clog2(DW) : 1;                   // quotient bit index
  localparam int EW = (DW > egcd_pkg::OPND_W) ? DW : egcd_pkg::OPND_W;
  localparam int XW = (SW > egcd_pkg::COEF_W) ? SW : egcd_pkg::COEF_W;

  logic [DW-1:0]        b_reg;
  logic [DW-1:0]        r0, r1, dsh;
  logic signed [SW-1:0] s0, s1, t0, t1, ssh, tsh;
  logic [CW-1:0]        cnt;

  logic [EW-1:0]        a_ext, b_ext, g_ext, i_ext;
  logic signed [XW-1:0] x_ext, y_ext;
  logic                 fits;
  logic                 exists;
  logic signed [SW-1:0] inv_full;
  logic [DW-1:0]        inv_val;

  assign a_ext = EW'(operands.a_value);
  assign b_ext = EW'(operands.b_value);

  // divisor multiple still fits under the running remainder
  assign fits = (dsh <= r0);

  assign status.r1_zero  = (r1 == '0);
  assign status.align_ok = ({dsh, 1'b0} <= {1'b0, r0});
  assign status.cnt_nz   = (cnt != '0);

  assign exists   = (r0 == DW'(1)) && (b_reg != '0);
  // |s0| < b whenever the inverse exists, so one conditional add normalizes it
  assign inv_full = s0[SW-1] ? s0 + $signed(SW'(b_reg)) : s0;
  assign inv_val  = exists ? inv_full[DW-1:0] : '0;

  assign g_ext = EW'(r0);
  assign i_ext = EW'(inv_val);
  assign x_ext = XW'(s0);
  assign y_ext = XW'(t0);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (op == egcd_pkg::OP_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    unique case (op)
      egcd_pkg::OP_NOP: begin
      end
      egcd_pkg::OP_LOAD: begin
        b_reg <= b_ext[DW-1:0];
        r0    <= a_ext[DW-1:0];
        r1    <= b_ext[DW-1:0];
        s0    <= SW'(1);
        s1    <= '0;
        t0    <= '0;
        t1    <= SW'(1);
      end
      egcd_pkg::OP_INIT: begin
        dsh <= r1;
        ssh <= s1;
        tsh <= t1;
        cnt <= '0;
      end
      egcd_pkg::OP_ALIGN: begin
        if (status.align_ok) begin
          dsh <= {dsh[DW-2:0], 1'b0};
          ssh <= ssh <<< 1;
          tsh <= tsh <<< 1;
          cnt <= cnt + CW'(1);
        end
      end
      egcd_pkg::OP_SUB: begin
        // one quotient bit: take off the shifted multiples from r0, s0, t0
        if (fits) begin
          r0 <= r0 - dsh;
          s0 <= s0 - ssh;
          t0 <= t0 - tsh;
        end
        if (status.cnt_nz) begin
          dsh <= dsh >> 1;
          ssh <= ssh >>> 1;
          tsh <= tsh >>> 1;
          cnt <= cnt - CW'(1);
        end
      end
      egcd_pkg::OP_SWAP: begin
        r0 <= r1;
        r1 <= r0;
        s0 <= s1;
        s1 <= s0;
        t0 <= t1;
        t1 <= t0;
      end
      egcd_pkg::OP_FINISH: begin
        result.gcd_value      <= g_ext[egcd_pkg::OPND_W-1:0];
        result.bezout_x       <= x_ext[egcd_pkg::COEF_W-1:0];
        result.bezout_y       <= y_ext[egcd_pkg::COEF_W-1:0];
        result.inverse_value  <= i_ext[egcd_pkg::OPND_W-1:0];
        result.inverse_exists <= exists;
      end
      egcd_pkg::OP_EMIT: begin
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: hdl/extended_gcd_modular_inverse_top.sv
// Extended Euclid / modular inverse: usage notes.
// Command port: drive operands and raise start; the word is taken at a clock
// edge with start high and busy low. busy stays high until the result is out.
// Result port: done is high for exactly one cycle with the result word valid
// on result (gcd, Bezout x and y, a^-1 mod b and its exists flag). There is no
// back-pressure; the receiver must take the word in that cycle.
// Run: each Euclid step does test, init, the align and subtract passes of the
// shift-subtract unit over the quotient bit positions, and swap; a run adds
// setup, final test, finish and emit. A new command can be taken the cycle
// done is high.
// The next command waits for the whole run: one datapath, one item at a time.
// Reset (rst, synchronous) returns the sequencer to idle and clears done.
// Operands are cut to DATA_WIDTH bits. Depends on egcd_pkg, egcd_seq,
// egcd_dpath.
module extended_gcd_modular_inverse_top #(
  parameter int DATA_WIDTH = 31
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  egcd_pkg::in_word_t   operands,
  output logic                 busy,
  output logic                 done,
  output egcd_pkg::out_word_t  result
);

  egcd_pkg::op_t     op;
  egcd_pkg::status_t status;

  egcd_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .op     (op),
    .busy   (busy)
  );

  egcd_dpath #(
    .DW (DATA_WIDTH)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .op       (op),
    .operands (operands),
    .status   (status),
    .done     (done),
    .result   (result)
  );

endmodule

FILE: hdl/egcd_checker.sv
// Port-level checks for the extended GCD block, bound to the top level.
// Depends on egcd_pkg and extended_gcd_modular_inverse_top.
module egcd_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                done,
  input egcd_pkg::out_word_t result
);

  // a taken command makes the block busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command taken but busy not raised");

  // result strobe only once the run is over
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done longer than one cycle");

  a_inv_gcd: assert property (@(posedge clk) disable iff (rst)
    (done && result.inverse_exists) |-> (result.gcd_value == egcd_pkg::OPND_W'(1)))
    else $error("inverse flagged with gcd not one");

endmodule

bind extended_gcd_modular_inverse_top egcd_checker u_chk (.*);

FILE: sim/tb_top.sv
// Self-checking bench for extended_gcd_modular_inverse_top: directed operand table, then
// shaped random pairs, each checked against a typed-in result or an in-bench Euclid model.
// Depends on egcd_pkg and the RTL under hdl/.
module tb_top;
  import egcd_pkg::*;

  localparam logic [OPND_W-1:0] OPND_MAX = {OPND_W{1'b1}};
  localparam int N_RANDOM    = 557;
  localparam int DRAIN_CYCLES = 300;   // a little over the worst-case run
  localparam int STALL_LIMIT = 4000;   // cycles with neither a command nor a result taken

  typedef enum int {
    SHAPE_FULL,
    SHAPE_SHARED,
    SHAPE_SMALL,
    SHAPE_PRIME_MOD,
    SHAPE_DEGENERATE,
    SHAPE_FIB,
    SHAPE_EDGE
  } shape_t;

  typedef struct {
    in_word_t  ops;
    bit        known;        // result typed in by hand, not from the model
    bit        drain_first;  // wait for every pending result before sending
    out_word_t res;
  } stim_t;

  typedef struct {
    in_word_t  ops;
    out_word_t res;
  } pending_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  in_word_t  operands = '0;
  logic      busy;
  logic      done;
  out_word_t result;

  stim_t    stim[$];
  pending_t pending[$];
  int next_item = 0;
  int n_directed = 0;
  int n_checked = 0;
  int n_inverse = 0;
  int n_zero_mod = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  bit timed_out = 0;

  extended_gcd_modular_inverse_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .operands (operands),
    .busy     (busy),
    .done     (done),
    .result   (result)
  );

  always #2 clk = ~clk;

  // Iterative extended Euclid; s/t held wide so the 32-bit report is a plain truncation.
  function automatic out_word_t euclid_predict(input in_word_t w);
    out_word_t        o;
    longint unsigned  r0, r1, rn, q, m, b, inv;
    longint           s0, s1, t0, t1, sn, tn;
    r0 = longint'(w.a_value);
    r1 = longint'(w.b_value);
    b  = r1;
    s0 = 1; s1 = 0; t0 = 0; t1 = 1;
    inv = 0;
    for (int it = 0; it < 2 * OPND_W + 4 && r1 != 0; it++) begin
      q  = r0 / r1;
      rn = r0 - q * r1;
      sn = s0 - longint'(q) * s1;
      tn = t0 - longint'(q) * t1;
      r0 = r1; r1 = rn;
      s0 = s1; s1 = sn;
      t0 = t1; t1 = tn;
    end
    o.inverse_exists = (r0 == 1 && b != 0);
    if (o.inverse_exists) begin
      if (s0 >= 0) begin
        inv = longint'(s0) % b;
      end else begin
        m = longint'(-s0) % b;
        inv = (m == 0) ? 0 : b - m;
      end
    end
    o.gcd_value     = r0[OPND_W-1:0];
    o.bezout_x      = s0[COEF_W-1:0];
    o.bezout_y      = t0[COEF_W-1:0];
    o.inverse_value = inv[OPND_W-1:0];
    return o;
  endfunction

  function automatic longint fib(input int k);
    longint f0, f1, fn;
    f0 = 0;
    f1 = 1;
    for (int i = 0; i < k; i++) begin
      fn = f0 + f1;
      f0 = f1;
      f1 = fn;
    end
    return f0;
  endfunction

  function automatic in_word_t random_operands();
    in_word_t w;
    shape_t   shape;
    int       pick, g, k;
    pick = $urandom_range(0, 99);
    if (pick < 40)      shape = SHAPE_FULL;
    else if (pick < 55) shape = SHAPE_SHARED;
    else if (pick < 70) shape = SHAPE_SMALL;
    else if (pick < 78) shape = SHAPE_PRIME_MOD;
    else if (pick < 86) shape = SHAPE_DEGENERATE;
    else if (pick < 93) shape = SHAPE_FIB;
    else                shape = SHAPE_EDGE;
    w.a_value = OPND_W'($urandom());
    w.b_value = OPND_W'($urandom());
    case (shape)
      SHAPE_SHARED: begin
        g = $urandom_range(2, 5000);
        w.a_value = OPND_W'($urandom_range(0, int'(OPND_MAX) / g) * g);
        w.b_value = OPND_W'($urandom_range(0, int'(OPND_MAX) / g) * g);
      end
      SHAPE_SMALL: begin
        w.a_value = OPND_W'($urandom_range(0, 255));
        w.b_value = OPND_W'($urandom_range(0, 255));
      end
      SHAPE_PRIME_MOD: begin
        w.b_value = OPND_MAX;  // 2^31-1 is prime
      end
      SHAPE_DEGENERATE: begin
        case ($urandom_range(0, 4))
          0: w.b_value = '0;
          1: w.a_value = '0;
          2: w.b_value = 1;
          3: w.a_value = 1;
          default: w.b_value = w.a_value;
        endcase
      end
      SHAPE_FIB: begin
        // consecutive Fibonacci numbers give the longest quotient chains
        k = $urandom_range(2, 45);
        w.a_value = OPND_W'(fib(k + 1));
        w.b_value = OPND_W'(fib(k));
        if ($urandom_range(0, 1)) w = '{a_value: w.b_value, b_value: w.a_value};
      end
      SHAPE_EDGE: begin
        w.a_value = OPND_W'(OPND_MAX - $urandom_range(0, 15));
        if ($urandom_range(0, 1)) w.b_value = OPND_W'(1 << $urandom_range(0, OPND_W - 1));
      end
      default: ;
    endcase
    return w;
  endfunction

  task automatic add_row(input logic [OPND_W-1:0] a, input logic [OPND_W-1:0] b);
    stim_t s;
    s.ops = '{a_value: a, b_value: b};
    s.known = 0;
    s.drain_first = 0;
    s.res = '0;
    stim.push_back(s);
  endtask

  task automatic add_known(input logic [OPND_W-1:0] a, input logic [OPND_W-1:0] b,
                           input logic [OPND_W-1:0] g, input int x, input int y,
                           input logic [OPND_W-1:0] inv, input logic ex);
    stim_t s;
    s.ops = '{a_value: a, b_value: b};
    s.known = 1;
    s.drain_first = 0;
    s.res = '{gcd_value: g, bezout_x: x, bezout_y: y, inverse_value: inv,
              inverse_exists: ex};
    stim.push_back(s);
  endtask

  task automatic check_field(input string fname, input logic [COEF_W-1:0] want,
                             input logic [COEF_W-1:0] got, input in_word_t ops);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch (a=%0d b=%0d): expected %0h, actual %0h",
               $time, fname, ops.a_value, ops.b_value, want, got);
    end
  endtask

  // Result checking and command driving share one block so queue order is fixed.
  always @(posedge clk) begin
    pending_t p;
    if (rst) begin
      start <= 1'b0;
      burst_left = $urandom_range(1, 12);
      gap_left = 0;
    end else begin
      idle_cycles++;
      if (done) begin
        idle_cycles = 0;
        if (pending.size() == 0) begin
          mismatches++;
          $display("%0t: result word with nothing expected: gcd=%0h x=%0h y=%0h", $time,
                   result.gcd_value, result.bezout_x, result.bezout_y);
        end else begin
          p = pending.pop_front();
          n_checked++;
          check_field("gcd_value", COEF_W'(p.res.gcd_value), COEF_W'(result.gcd_value),
                      p.ops);
          check_field("bezout_x", p.res.bezout_x, result.bezout_x, p.ops);
          check_field("bezout_y", p.res.bezout_y, result.bezout_y, p.ops);
          check_field("inverse_value", COEF_W'(p.res.inverse_value),
                      COEF_W'(result.inverse_value), p.ops);
          check_field("inverse_exists", COEF_W'(p.res.inverse_exists),
                      COEF_W'(result.inverse_exists), p.ops);
        end
      end

      if (start && !busy) begin
        idle_cycles = 0;
        p.ops = stim[next_item].ops;
        p.res = stim[next_item].known ? stim[next_item].res : euclid_predict(p.ops);
        pending.push_back(p);
        if (p.res.inverse_exists) n_inverse++;
        if (p.ops.b_value == '0) n_zero_mod++;
        next_item++;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
        end
      end

      // a pending word holds start and operands until busy drops
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (next_item < stim.size() &&
                     !(stim[next_item].drain_first && pending.size() != 0)) begin
          start <= 1'b1;
          operands <= stim[next_item].ops;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  initial begin
    stim_t s;
    // zero modulus, zero a and both-zero cases
    add_known('0, '0, '0, 1, 0, '0, 1'b0);
    add_known(1, '0, 1, 1, 0, '0, 1'b0);
    add_known(OPND_MAX, '0, OPND_MAX, 1, 0, '0, 1'b0);
    add_known('0, OPND_MAX, OPND_MAX, 0, 1, '0, 1'b0);
    add_known('0, 2, 2, 0, 1, '0, 1'b0);
    // modulus one: inverse exists and is zero
    add_known('0, 1, 1, 0, 1, '0, 1'b1);
    add_known(1, 1, 1, 0, 1, '0, 1'b1);
    add_known(OPND_MAX, 1, 1, 0, 1, '0, 1'b1);
    add_known(OPND_MAX, OPND_MAX, OPND_MAX, 0, 1, '0, 1'b0);
    add_known(1, OPND_MAX, 1, 1, 0, 1, 1'b1);
    add_row(3, 7);
    add_row(6, 4);
    add_row(240, 46);
    add_row(OPND_MAX, OPND_W'(OPND_MAX - 1));
    add_row(OPND_W'(OPND_MAX - 1), OPND_MAX);
    add_row(1836311903, 1134903170);  // F46, F45
    add_row(1134903170, 1836311903);
    add_row(2, OPND_MAX);
    add_row(12345, OPND_MAX);
    add_row(OPND_MAX, 2);
    add_row(31'h5555_5555, 31'h2AAA_AAAA);
    add_row(31'h2AAA_AAAA, 31'h5555_5555);
    add_row(31'h4000_0000, 3);
    n_directed = stim.size();

    for (int i = 0; i < N_RANDOM; i++) begin
      s.ops = random_operands();
      s.known = 0;
      s.res = '0;
      s.drain_first = (i == 0 || i == 200 || i == 400);
      stim.push_back(s);
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    fork
      begin
        while (next_item < stim.size() || pending.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
      end
      begin
        while (idle_cycles < STALL_LIMIT) @(negedge clk);
        timed_out = 1;
      end
    join_any

    if (timed_out) begin
      $display("%0t: no progress for %0d cycles, %0d words still pending", $time,
               STALL_LIMIT, pending.size());
      $display("** extended_gcd_modular_inverse_top: FAILED **");
    end else begin
      $display("Sent %0d operand pairs (%0d directed), checked %0d results.",
               next_item, n_directed, n_checked);
      $display("%0d had an inverse, %0d had a zero modulus; %0d mismatches.",
               n_inverse, n_zero_mod, mismatches);
      if (mismatches == 0) begin
        $display("** extended_gcd_modular_inverse_top: PASSED **");
      end else begin
        $display("** extended_gcd_modular_inverse_top: FAILED **");
      end
    end
    $finish;
  end

endmodule
